### rtl/core/assert_macros.svh
// Assertion helpers for the block checkers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a consequence in the same cycle
`define WLG_ASSERT_NOW(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("wlg check failed");

// Check a consequence in the next cycle
`define WLG_ASSERT_NEXT(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("wlg check failed");

`endif

### rtl/core/wlg_pkg.sv
package wlg_pkg;

	localparam int TS_W   = 16;
	localparam int FREQ_W = 24;
	localparam int AMP_W  = 16;
	localparam int DUTY_W = 16;
	localparam int OUT_W  = 16;
	localparam int CFG_W  = 24;
	localparam int VAL_W  = 18;
	localparam int PROD_W = TS_W + 1 + FREQ_W;

	localparam logic [2:0] WAVE_SINE     = 3'd0;
	localparam logic [2:0] WAVE_TRIANGLE = 3'd1;
	localparam logic [2:0] WAVE_SQUARE   = 3'd2;
	localparam logic [2:0] WAVE_SAW      = 3'd3;
	localparam logic [2:0] WAVE_INV_SAW  = 3'd4;
	localparam logic [2:0] WAVE_PWM      = 3'd5;

	localparam logic [1:0] REG_WAVE = 2'd0;
	localparam logic [1:0] REG_FREQ = 2'd1;
	localparam logic [1:0] REG_AMP  = 2'd2;
	localparam logic [1:0] REG_DUTY = 2'd3;

	localparam logic signed [VAL_W-1:0] ONE_Q16 = 18'sd65536;

	localparam int QUEUE_AW    = 2;
	localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

	typedef struct packed {
		logic [2:0]               wave_sel;
		logic signed [AMP_W-1:0]  amp;
		logic [DUTY_W-1:0]        duty;
	} wlg_cfg_t;

endpackage

### rtl/core/wlg_front.sv
module wlg_front
	import wlg_pkg::*;
#(
	parameter int PHASE_BITS = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [TS_W-1:0]          time_step,
	input  logic signed [FREQ_W-1:0] freq_hz,
	input  logic [QUEUE_AW:0]        q_count,
	output logic                     push,
	output logic [PHASE_BITS-1:0]    push_phase
);

	localparam int UP   = (PHASE_BITS >= 32) ? PHASE_BITS - 32 : 0;
	localparam int DOWN = (PHASE_BITS < 32) ? 32 - PHASE_BITS : 0;

	logic                       vld_s1;
	logic signed [PROD_W-1:0]   prod_s1;
	logic [PHASE_BITS-1:0]      phase_acc_q;
	logic signed [63:0]         prod_ext;
	logic signed [63:0]         shifted;
	logic [PHASE_BITS-1:0]      inc;
	logic [QUEUE_AW+1:0]        used;
	logic                       accept;

	assign used     = {1'b0, q_count} + (QUEUE_AW+2)'(vld_s1);
	assign in_ready = used < (QUEUE_AW+2)'(QUEUE_DEPTH);
	assign accept   = in_valid && in_ready;

	assign prod_ext   = {{(64-PROD_W){prod_s1[PROD_W-1]}}, prod_s1};
	assign shifted    = (prod_ext >>> DOWN) <<< UP;
	assign inc        = shifted[PHASE_BITS-1:0];
	assign push       = vld_s1;
	assign push_phase = phase_acc_q + inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			phase_acc_q <= '0;
		end else begin
			vld_s1 <= accept;
			if (vld_s1) begin
				phase_acc_q <= push_phase;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prod_s1 <= $signed({1'b0, time_step}) * freq_hz;
		end
	end

endmodule

### rtl/core/wlg_queue.sv
module wlg_queue
	import wlg_pkg::*;
#(
	parameter int WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [WIDTH-1:0]  push_data,
	input  logic              pop,
	output logic [WIDTH-1:0]  pop_data,
	output logic              empty,
	output logic [QUEUE_AW:0] count
);

	logic [WIDTH-1:0]    mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign pop_data = mem_q[rd_ptr_q];
	assign empty    = (count_q == '0);
	assign count    = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### rtl/core/wlg_back.sv
module wlg_back
	import wlg_pkg::*;
#(
	parameter int PHASE_BITS       = 32,
	parameter int SINE_TABLE_DEPTH = 256
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  wlg_cfg_t                cfg,
	input  logic                    q_empty,
	input  logic [PHASE_BITS-1:0]   q_data,
	output logic                    pop,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [OUT_W-1:0] wave_out,
	output logic [15:0]             phase_now
);

	localparam int IW = $clog2(4 * SINE_TABLE_DEPTH + 1);
	localparam int AW = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int MW = PHASE_BITS + IW;
	localparam logic [IW-1:0] D1 = IW'(SINE_TABLE_DEPTH);
	localparam logic [IW-1:0] D2 = IW'(2 * SINE_TABLE_DEPTH);
	localparam logic [IW-1:0] D3 = IW'(3 * SINE_TABLE_DEPTH);
	localparam logic [IW-1:0] D4 = IW'(4 * SINE_TABLE_DEPTH);

	typedef logic [16:0] rom_t [0:SINE_TABLE_DEPTH];

	function automatic rom_t build_rom();
		rom_t               rom;
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic signed [63:0] sum;
		logic signed [63:0] r;
		int                 k;
		for (k = 0; k <= SINE_TABLE_DEPTH; k++) begin
			x = (64'(k) * 64'd1686629713 + 64'(SINE_TABLE_DEPTH / 2)) / SINE_TABLE_DEPTH;
			x2 = (x * x) >> 30;
			term = x;
			sum = $signed(x);
			term = ((term * x2) >> 30) / 64'd6;
			sum = sum - $signed(term);
			term = ((term * x2) >> 30) / 64'd20;
			sum = sum + $signed(term);
			term = ((term * x2) >> 30) / 64'd42;
			sum = sum - $signed(term);
			term = ((term * x2) >> 30) / 64'd72;
			sum = sum + $signed(term);
			term = ((term * x2) >> 30) / 64'd110;
			sum = sum - $signed(term);
			term = ((term * x2) >> 30) / 64'd156;
			sum = sum + $signed(term);
			if (sum < 0) begin
				sum = 0;
			end
			r = (sum + 64'sd8192) >>> 14;
			if (r > 64'sd65536) begin
				r = 64'sd65536;
			end
			rom[k] = r[16:0];
		end
		return rom;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	logic adv;

	logic                    vld_s1;
	logic [PHASE_BITS-1:0]   ph_s1;
	logic [IW-1:0]           idx_s1;

	logic                    vld_s2;
	logic [AW-1:0]           addr_s2;
	logic                    neg_s2;
	logic                    sine_s2;
	logic signed [VAL_W-1:0] vo_s2;
	logic [15:0]             pn_s2;

	logic                    vld_s3;
	logic [16:0]             rom_s3;
	logic                    neg_s3;
	logic                    sine_s3;
	logic signed [VAL_W-1:0] vo_s3;
	logic [15:0]             pn_s3;

	logic                    vld_s4;
	logic signed [AMP_W+VAL_W-1:0] prod_s4;
	logic [15:0]             pn_s4;

	logic                    out_valid_q;
	logic signed [OUT_W-1:0] wave_q;
	logic [15:0]             phase_q;

	logic [MW-1:0]           scaled;
	logic [IW-1:0]           wrap;
	logic [IW-1:0]           kk;
	logic [1:0]              quad;
	logic [AW-1:0]           addr;
	logic [15:0]             u;
	logic signed [18:0]      ue;
	logic signed [18:0]      v19;
	logic signed [VAL_W-1:0] vo;
	logic signed [VAL_W-1:0] rs;
	logic signed [VAL_W-1:0] v;
	logic signed [AMP_W+VAL_W:0] rnd;
	logic signed [18:0]      shr;
	logic signed [OUT_W-1:0] sat;

	assign adv = !out_valid_q || out_ready;
	assign pop = adv && !q_empty;

	assign scaled = MW'(q_data) * MW'(4 * SINE_TABLE_DEPTH) + (MW'(1) << (PHASE_BITS - 1));

	always_comb begin
		wrap = (idx_s1 >= D4) ? idx_s1 - D4 : idx_s1;
		if (wrap < D1) begin
			quad = 2'd0;
			kk   = wrap;
		end else if (wrap < D2) begin
			quad = 2'd1;
			kk   = wrap - D1;
		end else if (wrap < D3) begin
			quad = 2'd2;
			kk   = wrap - D2;
		end else begin
			quad = 2'd3;
			kk   = wrap - D3;
		end
		addr = quad[0] ? AW'(D1 - kk) : AW'(kk);
	end

	always_comb begin
		u   = ph_s1[PHASE_BITS-1 -: 16];
		ue  = $signed({3'b000, u});
		v19 = '0;
		case (cfg.wave_sel)
			WAVE_TRIANGLE: begin
				if (u < 16'd16384) begin
					v19 = ue <<< 2;
				end else if (u < 16'd49152) begin
					v19 = 19'sd65536 - ((ue - 19'sd16384) <<< 2);
				end else begin
					v19 = ((ue - 19'sd49152) <<< 2) - 19'sd65536;
				end
			end
			WAVE_SQUARE: begin
				v19 = (ph_s1 <= (PHASE_BITS'(1) << (PHASE_BITS - 1))) ? 19'sd65536 : -19'sd65536;
			end
			WAVE_SAW: begin
				v19 = (ue <<< 1) - 19'sd65536;
			end
			WAVE_INV_SAW: begin
				v19 = 19'sd65536 - (ue <<< 1);
			end
			WAVE_PWM: begin
				v19 = (ph_s1 <= (PHASE_BITS'(cfg.duty) << (PHASE_BITS - 16))) ?
					19'sd65536 : -19'sd65536;
			end
			default: begin
				v19 = '0;
			end
		endcase
		vo = v19[VAL_W-1:0];
	end

	assign rs = $signed({1'b0, rom_s3});
	assign v  = sine_s3 ? (neg_s3 ? -rs : rs) : vo_s3;

	always_comb begin
		rnd = (AMP_W+VAL_W+1)'(prod_s4) + (AMP_W+VAL_W+1)'(32768);
		shr = 19'(rnd >>> 16);
		if (shr > 19'sd32767) begin
			sat = 16'sh7fff;
		end else if (shr < -19'sd32768) begin
			sat = 16'sh8000;
		end else begin
			sat = shr[OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			vld_s4      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s1      <= !q_empty;
			vld_s2      <= vld_s1;
			vld_s3      <= vld_s2;
			vld_s4      <= vld_s3;
			out_valid_q <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ph_s1   <= q_data;
			idx_s1  <= scaled[MW-1:PHASE_BITS];
			addr_s2 <= addr;
			neg_s2  <= quad[1];
			sine_s2 <= (cfg.wave_sel == WAVE_SINE);
			vo_s2   <= vo;
			pn_s2   <= u;
			rom_s3  <= SINE_ROM[addr_s2];
			neg_s3  <= neg_s2;
			sine_s3 <= sine_s2;
			vo_s3   <= vo_s2;
			pn_s3   <= pn_s2;
			prod_s4 <= cfg.amp * v;
			pn_s4   <= pn_s3;
			wave_q  <= sat;
			phase_q <= pn_s4;
		end
	end

	assign out_valid = out_valid_q;
	assign wave_out  = wave_q;
	assign phase_now = phase_q;

endmodule

### rtl/core/waveform_lfo_generator.sv
// Phase-accumulator LFO. Each input item carries a time step; the phase advances by
// time step times frequency and the selected waveform (sine, triangle, square, sawtooth,
// inverse sawtooth, PWM) is scaled by the gain and saturated to 16 bits. Up to one item
// is taken per clock while the queue has room: the only loop is the phase add in the
// front end. An item is written into the four-entry queue after the front-end stage
// register and can be popped once the queue holds it; the back-end stage registers and
// the output register then carry it to m_axis_tvalid, and it waits longer when the
// output is stalled or older items wait in the queue.
// Configuration is written with cfg_we and must only change while idle.
module waveform_lfo_generator
	import wlg_pkg::*;
#(
	parameter int PHASE_BITS       = 32,
	parameter int SINE_TABLE_DEPTH = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [15:0]      s_axis_tdata,  // [15:0] time_step
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [31:0]      m_axis_tdata,  // [15:0] wave_out, [31:16] phase_now
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	logic [2:0]               wave_sel_q;
	logic signed [FREQ_W-1:0] freq_q;
	logic signed [AMP_W-1:0]  amp_q;
	logic [DUTY_W-1:0]        duty_q;
	wlg_cfg_t                 cfg;

	logic                     push;
	logic [PHASE_BITS-1:0]    push_phase;
	logic                     pop;
	logic [PHASE_BITS-1:0]    pop_phase;
	logic                     q_empty;
	logic [QUEUE_AW:0]        q_count;
	logic signed [OUT_W-1:0]  wave_out;
	logic [15:0]              phase_now;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_sel_q <= WAVE_SINE;
			freq_q     <= 24'sd65536;
			amp_q      <= 16'sd256;
			duty_q     <= 16'd32768;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WAVE: wave_sel_q <= cfg_data[2:0];
				REG_FREQ: freq_q     <= $signed(cfg_data[FREQ_W-1:0]);
				REG_AMP:  amp_q      <= $signed(cfg_data[AMP_W-1:0]);
				REG_DUTY: duty_q     <= cfg_data[DUTY_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg.wave_sel = wave_sel_q;
	assign cfg.amp      = amp_q;
	assign cfg.duty     = duty_q;

	wlg_front #(
		.PHASE_BITS(PHASE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.time_step (s_axis_tdata),
		.freq_hz   (freq_q),
		.q_count   (q_count),
		.push      (push),
		.push_phase(push_phase)
	);

	wlg_queue #(
		.WIDTH(PHASE_BITS)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_phase),
		.pop      (pop),
		.pop_data (pop_phase),
		.empty    (q_empty),
		.count    (q_count)
	);

	wlg_back #(
		.PHASE_BITS      (PHASE_BITS),
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.q_empty  (q_empty),
		.q_data   (pop_phase),
		.pop      (pop),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.wave_out (wave_out),
		.phase_now(phase_now)
	);

	assign m_axis_tdata = {phase_now, wave_out};

endmodule

### rtl/core/wlg_checker.sv
`include "assert_macros.svh"

module wlg_checker
	import wlg_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             s_axis_tvalid,
	input logic             s_axis_tready,
	input logic [15:0]      s_axis_tdata,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [31:0]      m_axis_tdata,
	input logic             cfg_we,
	input logic [1:0]       cfg_index,
	input logic [CFG_W-1:0] cfg_data
);

	logic [4:0] pend_q;
	logic       in_acc;
	logic       out_acc;
	logic       cfg_seen;

	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign out_acc  = m_axis_tvalid && m_axis_tready;
	assign cfg_seen = cfg_we && (cfg_data != '0 || cfg_index != '0 || s_axis_tdata != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 5'(in_acc) - 5'(out_acc);
		end
	end

	`WLG_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`WLG_ASSERT_NEXT(a_out_stable, clk, arst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
	`WLG_ASSERT_NOW(a_no_spurious, clk, arst_n, out_acc, pend_q != 5'd0)
	`WLG_ASSERT_NOW(a_bounded, clk, arst_n, in_acc || cfg_seen, pend_q < 5'd10)

endmodule

bind waveform_lfo_generator wlg_checker u_wlg_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tdata (s_axis_tdata),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.cfg_we       (cfg_we),
	.cfg_index    (cfg_index),
	.cfg_data     (cfg_data)
);
